### rtl/ppu_register_and_vram_port_defines.svh
// Assertion macros shared by the register port checker.
`ifndef PPU_REGISTER_AND_VRAM_PORT_DEFINES_SVH
`define PPU_REGISTER_AND_VRAM_PORT_DEFINES_SVH

// Check cons in the cycle after ante, outside reset.
`define PPU_RVP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Check cons in the same cycle as ante, outside reset.
`define PPU_RVP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/ppu_rvp_pkg.sv
// Shared codes, types and address helpers of the picture-processor register port.
package ppu_rvp_pkg;

    localparam int NtDepth  = 2048;
    localparam int PalDepth = 32;
    localparam int PatDepth = 8192;
    localparam int SprDepth = 256;
    localparam int DataW    = 8;

    // Item kinds carried in the func field.
    localparam logic [2:0] FUNC_CPU_READ  = 3'd0;
    localparam logic [2:0] FUNC_CPU_WRITE = 3'd1;
    localparam logic [2:0] FUNC_VBLANK    = 3'd2;
    localparam logic [2:0] FUNC_PRERENDER = 3'd3;
    localparam logic [2:0] FUNC_SPR0_HIT  = 3'd4;
    localparam logic [2:0] FUNC_OVERFLOW  = 3'd5;

    // Register numbers.
    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_MASK    = 3'd1;
    localparam logic [2:0] REG_STATUS  = 3'd2;
    localparam logic [2:0] REG_OAMADDR = 3'd3;
    localparam logic [2:0] REG_OAMDATA = 3'd4;
    localparam logic [2:0] REG_SCROLL  = 3'd5;
    localparam logic [2:0] REG_ADDR    = 3'd6;
    localparam logic [2:0] REG_DATA    = 3'd7;

    localparam logic [13:0] PAL_BASE = 14'h3F00;

    typedef struct packed {
        logic        spr_we;
        logic        spr_re;
        logic [7:0]  spr_addr;
        logic        pat_we;
        logic        pat_re;
        logic [12:0] pat_addr;
        logic        nt_we;
        logic        nt_re;
        logic [10:0] nt_addr;
        logic        pal_we;
        logic        pal_re;
        logic [4:0]  pal_addr;
        logic [7:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic [7:0] spr;
        logic [7:0] pat;
        logic [7:0] nt;
        logic [7:0] pal;
    } mem_rdata_t;

    // Fold a video address onto 2 KB of nametable RAM.
    function automatic logic [10:0] nt_index(logic [13:0] a, logic vert);
        return vert ? a[10:0] : {a[11], a[9:0]};
    endfunction

    // Backdrop entries of the sprite palettes alias to the background ones.
    function automatic logic [4:0] pal_index(logic [13:0] a);
        logic [4:0] p;
        p = a[4:0];
        if (p[4] && (p[1:0] == 2'b00)) begin
            p[4] = 1'b0;
        end
        return p;
    endfunction

endpackage

### rtl/ppu_rvp_ram.sv
// Generic single-port RAM with registered read.
module ppu_rvp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic             re,
    input  logic [AddrW-1:0] addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ppu_rvp_core.sv
// Register file, scroll latches and per-item update of the register port.
module ppu_rvp_core
    import ppu_rvp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [2:0]  func,
    input  logic [2:0]  reg_select,
    input  logic [7:0]  write_data,
    input  logic        mirror_mode,
    input  mem_rdata_t  mem_rdata,
    output mem_req_t    mem_req,
    output logic [7:0]  read_data,
    output logic        nmi,
    output logic [15:0] vram_addr,
    output logic [15:0] temp_addr,
    output logic [2:0]  fine_x,
    output logic [7:0]  control,
    output logic [7:0]  mask
);

    // Where the returned byte comes from.
    typedef enum logic [1:0] {RD_VALUE, RD_SPRITE, RD_PALETTE} rd_src_t;
    // Which RAM output currently holds the read buffer.
    typedef enum logic [1:0] {BUF_ZERO, BUF_PAT, BUF_NT, BUF_PAL} buf_src_t;

    logic [7:0]  spr_addr_reg, spr_addr_next;
    logic [15:0] cur_reg, cur_next;
    logic [15:0] tmp_reg, tmp_next;
    logic [2:0]  fine_reg, fine_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  mask_reg, mask_next;
    logic [2:0]  status_reg, status_next;
    buf_src_t    buf_src_reg, buf_src_next;
    rd_src_t     rd_src_reg, rd_src_next;
    logic [7:0]  rd_val_reg, rd_val_next;
    logic        nmi_reg, nmi_next;

    logic [13:0] va;
    logic        in_pat;
    logic        in_pal;
    logic [15:0] step;
    logic [7:0]  buffer;

    assign va     = cur_reg[13:0];
    assign in_pat = ~va[13];
    assign in_pal = (va >= PAL_BASE);
    assign step   = ctrl_reg[2] ? 16'd32 : 16'd1;

    always_comb begin
        case (buf_src_reg)
            BUF_PAT: buffer = mem_rdata.pat;
            BUF_NT:  buffer = mem_rdata.nt;
            BUF_PAL: buffer = mem_rdata.pal;
            default: buffer = 8'h00;
        endcase
    end

    always_comb begin
        spr_addr_next = spr_addr_reg;
        cur_next      = cur_reg;
        tmp_next      = tmp_reg;
        fine_next     = fine_reg;
        toggle_next   = toggle_reg;
        ctrl_next     = ctrl_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        buf_src_next  = buf_src_reg;
        rd_src_next   = RD_VALUE;
        rd_val_next   = 8'h00;
        nmi_next      = 1'b0;

        mem_req          = '0;
        mem_req.spr_addr = spr_addr_reg;
        mem_req.pat_addr = va[12:0];
        mem_req.nt_addr  = nt_index(va, mirror_mode);
        mem_req.pal_addr = pal_index(va);
        mem_req.wdata    = write_data;

        if (accept) begin
            case (func)
                FUNC_CPU_READ: begin
                    case (reg_select)
                        REG_STATUS: begin
                            rd_val_next    = {status_reg, 5'b00000};
                            status_next[2] = 1'b0;
                            toggle_next    = 1'b0;
                        end
                        REG_OAMDATA: begin
                            mem_req.spr_re = 1'b1;
                            rd_src_next    = RD_SPRITE;
                        end
                        REG_DATA: begin
                            // Return the old buffer (palette reads: the palette byte); refill it from the video bus.
                            rd_val_next = buffer;
                            if (in_pat) begin
                                mem_req.pat_re = 1'b1;
                                buf_src_next   = BUF_PAT;
                            end else if (!in_pal) begin
                                mem_req.nt_re = 1'b1;
                                buf_src_next  = BUF_NT;
                            end else begin
                                mem_req.pal_re = 1'b1;
                                buf_src_next   = BUF_PAL;
                                rd_src_next    = RD_PALETTE;
                            end
                            cur_next = cur_reg + step;
                        end
                        default: ;
                    endcase
                end
                FUNC_CPU_WRITE: begin
                    case (reg_select)
                        REG_CTRL: begin
                            ctrl_next         = write_data;
                            tmp_next[11:10]   = write_data[1:0];
                        end
                        REG_MASK: mask_next = write_data;
                        REG_OAMADDR: spr_addr_next = write_data;
                        REG_OAMDATA: begin
                            mem_req.spr_we = 1'b1;
                            spr_addr_next  = spr_addr_reg + 8'd1;
                        end
                        REG_SCROLL: begin
                            if (!toggle_reg) begin
                                fine_next     = write_data[2:0];
                                tmp_next[4:0] = write_data[7:3];
                            end else begin
                                tmp_next[14:12] = write_data[2:0];
                                tmp_next[9:5]   = write_data[7:3];
                            end
                            toggle_next = ~toggle_reg;
                        end
                        REG_ADDR: begin
                            if (!toggle_reg) begin
                                tmp_next[15:8] = {2'b00, write_data[5:0]};
                            end else begin
                                tmp_next[7:0] = write_data;
                                cur_next      = {tmp_reg[15:8], write_data};
                            end
                            toggle_next = ~toggle_reg;
                        end
                        REG_DATA: begin
                            mem_req.pat_we = in_pat;
                            mem_req.nt_we  = ~in_pat & ~in_pal;
                            mem_req.pal_we = in_pal;
                            cur_next       = cur_reg + step;
                        end
                        default: ;
                    endcase
                end
                FUNC_VBLANK: begin
                    status_next[2] = 1'b1;
                    nmi_next       = ctrl_reg[7];
                end
                FUNC_PRERENDER: status_next = 3'b000;
                FUNC_SPR0_HIT:  status_next[1] = 1'b1;
                FUNC_OVERFLOW:  status_next[0] = 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spr_addr_reg <= '0;
            cur_reg      <= '0;
            tmp_reg      <= '0;
            fine_reg     <= '0;
            toggle_reg   <= 1'b0;
            ctrl_reg     <= '0;
            mask_reg     <= '0;
            status_reg   <= '0;
            buf_src_reg  <= BUF_ZERO;
            rd_src_reg   <= RD_VALUE;
            rd_val_reg   <= '0;
            nmi_reg      <= 1'b0;
        end else if (accept) begin
            spr_addr_reg <= spr_addr_next;
            cur_reg      <= cur_next;
            tmp_reg      <= tmp_next;
            fine_reg     <= fine_next;
            toggle_reg   <= toggle_next;
            ctrl_reg     <= ctrl_next;
            mask_reg     <= mask_next;
            status_reg   <= status_next;
            buf_src_reg  <= buf_src_next;
            rd_src_reg   <= rd_src_next;
            rd_val_reg   <= rd_val_next;
            nmi_reg      <= nmi_next;
        end
    end

    always_comb begin
        case (rd_src_reg)
            RD_SPRITE:  read_data = mem_rdata.spr;
            RD_PALETTE: read_data = mem_rdata.pal;
            default:    read_data = rd_val_reg;
        endcase
    end

    assign nmi       = nmi_reg;
    assign vram_addr = cur_reg;
    assign temp_addr = tmp_reg;
    assign fine_x    = fine_reg;
    assign control   = ctrl_reg;
    assign mask      = mask_reg;

endmodule

### rtl/ppu_register_and_vram_port.sv
// Top level of the picture-processor register port with its video memories.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------
//  s_      | in        | s_tvalid / s_tready      | s_tuser: func, reg_select; s_tdata: byte
//  m_      | out       | m_tvalid / m_tready      | m_tdata: read byte, nmi, addresses, regs
//  cfg_    | in        | cfg_valid / cfg_ready    | cfg_data: mirror_mode
//
// One transaction per cycle unless m_ stalls: each item touches at most one
// RAM entry, issued at the accept edge; the RAM read register loads there too
// and feeds the result directly; it shows in the cycle after its accept.
// The result register holds one transaction; a new one is taken when it is
// empty or drained in the same cycle, so a stalled m_ side stalls s_.
// Reset (aresetn low, synchronous) clears the latches and flags; the RAMs
// keep their contents and need no clearing pass.
module ppu_register_and_vram_port
    import ppu_rvp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] write_data
    input  logic [7:0]  s_tdata,
    // [2:0] func, [5:3] reg_select
    input  logic [5:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] nmi, [24:9] vram_addr, [40:25] temp_addr,
    // [43:41] fine_x, [51:44] control, [59:52] mask, [63:60] zero
    output logic [63:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic        accept;
    logic        m_valid_reg;
    logic        mirror_reg;
    mem_req_t    mem_req;
    mem_rdata_t  mem_rdata;
    logic [7:0]  read_data;
    logic        nmi;
    logic [15:0] vram_addr;
    logic [15:0] temp_addr;
    logic [2:0]  fine_x;
    logic [7:0]  control;
    logic [7:0]  mask;

    // Take a new transaction when the result slot is free or being drained.
    assign s_tready  = ~m_valid_reg | m_tready;
    assign accept    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            mirror_reg  <= 1'b0;
        end else begin
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                mirror_reg <= cfg_data;
            end
        end
    end

    ppu_rvp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .func        (s_tuser[2:0]),
        .reg_select  (s_tuser[5:3]),
        .write_data  (s_tdata),
        .mirror_mode (mirror_reg),
        .mem_rdata   (mem_rdata),
        .mem_req     (mem_req),
        .read_data   (read_data),
        .nmi         (nmi),
        .vram_addr   (vram_addr),
        .temp_addr   (temp_addr),
        .fine_x      (fine_x),
        .control     (control),
        .mask        (mask)
    );

    // Sprite memory.
    ppu_rvp_ram #(.WIDTH(DataW), .DEPTH(SprDepth)) u_spr_ram (
        .aclk  (aclk),
        .we    (mem_req.spr_we),
        .re    (mem_req.spr_re),
        .addr  (mem_req.spr_addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata.spr)
    );

    // Flat pattern space.
    ppu_rvp_ram #(.WIDTH(DataW), .DEPTH(PatDepth)) u_pat_ram (
        .aclk  (aclk),
        .we    (mem_req.pat_we),
        .re    (mem_req.pat_re),
        .addr  (mem_req.pat_addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata.pat)
    );

    // Mirrored nametables.
    ppu_rvp_ram #(.WIDTH(DataW), .DEPTH(NtDepth)) u_nt_ram (
        .aclk  (aclk),
        .we    (mem_req.nt_we),
        .re    (mem_req.nt_re),
        .addr  (mem_req.nt_addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata.nt)
    );

    // Palette, read unbuffered.
    ppu_rvp_ram #(.WIDTH(DataW), .DEPTH(PalDepth)) u_pal_ram (
        .aclk  (aclk),
        .we    (mem_req.pal_we),
        .re    (mem_req.pal_re),
        .addr  (mem_req.pal_addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata.pal)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'h0, mask, control, fine_x, temp_addr, vram_addr, nmi, read_data};

endmodule

### rtl/ppu_rvp_checker.sv
// Port-level checks of the register port, bound to the top level.
`include "ppu_register_and_vram_port_defines.svh"

module ppu_rvp_checker
    import ppu_rvp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [5:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    logic       s_fire;
    logic       m_stall;
    logic       mask_wr;
    logic       non_vbl;
    logic [7:0] m_mask;

    assign s_fire  = s_tvalid & s_tready;
    assign m_stall = m_tvalid & ~m_tready;
    assign mask_wr = s_fire && (s_tuser == {REG_MASK, FUNC_CPU_WRITE});
    assign non_vbl = s_fire && (s_tuser[2:0] != FUNC_VBLANK);
    assign m_mask  = m_tdata[59:52];

    `PPU_RVP_ASSERT_NEXT(a_hold, m_stall, m_tvalid && $stable(m_tdata), "stalled result moved")
    `PPU_RVP_ASSERT_SAME(a_ready_empty, !m_tvalid, s_tready, "input stalled while empty")
    `PPU_RVP_ASSERT_NEXT(a_mask, mask_wr, m_tvalid && m_mask == $past(s_tdata), "mask lost")
    `PPU_RVP_ASSERT_NEXT(a_nmi, non_vbl, m_tvalid && !m_tdata[8], "stray nmi")

endmodule

bind ppu_register_and_vram_port ppu_rvp_checker u_checker (.*);

### sim/ppu_register_and_vram_port_tb.sv
// Self-checking testbench for the picture-processor register port and its video memories.
module ppu_register_and_vram_port_tb
    import ppu_rvp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Spare item kinds: the port must treat them as no-ops.
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;

    // Status flag bit positions inside the 3-bit flag set.
    localparam int VblBit = 2;
    localparam int HitBit = 1;
    localparam int OvfBit = 0;

    // Watchdog: cycles without any transaction before the run is declared hung.
    localparam int StallLimit = 2000;
    // Length of the deliberate result-side hold-off.
    localparam int HoldCycles = 300;

    // Register view reported with every result.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        nmi;
        logic [15:0] vram_addr;
        logic [15:0] temp_addr;
        logic [2:0]  fine_x;
        logic [7:0]  control;
        logic [7:0]  mask;
    } reg_snapshot_t;

    // Shadow of the port: latches, flags and memories, plus the snapshots
    // still owed by the block.
    class ppu_port_scoreboard;
        logic [7:0]  nt_mem  [NtDepth];
        logic [7:0]  pal_mem [PalDepth];
        logic [7:0]  pat_mem [PatDepth];
        logic [7:0]  spr_mem [SprDepth];
        bit          nt_set  [NtDepth];
        bit          pal_set [PalDepth];
        bit          pat_set [PatDepth];
        bit          spr_set [SprDepth];
        logic [7:0]  oam_ptr   = '0;
        logic [7:0]  rd_buffer = '0;
        logic [15:0] vaddr     = '0;
        logic [15:0] taddr     = '0;
        logic [2:0]  fine      = '0;
        logic        toggle    = 1'b0;
        logic [7:0]  ctrl      = '0;
        logic [7:0]  msk       = '0;
        logic [2:0]  flags     = '0;
        logic        mirror    = 1'b0;
        int          errors    = 0;
        reg_snapshot_t owed_snapshots[$];

        function int pending();
            return owed_snapshots.size();
        endfunction

        function logic [10:0] nt_slot(logic [13:0] a);
            return mirror ? a[10:0] : {a[11], a[9:0]};
        endfunction

        function logic [4:0] pal_slot(logic [13:0] a);
            logic [4:0] p;
            p = a[4:0];
            if ((p & 5'h13) == 5'h10) begin
                p = p & 5'h0F;
            end
            return p;
        endfunction

        function bit entry_written(logic [13:0] a);
            if (a < 14'h2000) begin
                return pat_set[a[12:0]];
            end else if (a < PAL_BASE) begin
                return nt_set[nt_slot(a)];
            end
            return pal_set[pal_slot(a)];
        endfunction

        function logic [7:0] mem_read(logic [13:0] a);
            if (a < 14'h2000) begin
                return pat_mem[a[12:0]];
            end else if (a < PAL_BASE) begin
                return nt_mem[nt_slot(a)];
            end
            return pal_mem[pal_slot(a)];
        endfunction

        function void mem_write(logic [13:0] a, logic [7:0] d);
            if (a < 14'h2000) begin
                pat_mem[a[12:0]] = d;
                pat_set[a[12:0]] = 1'b1;
            end else if (a < PAL_BASE) begin
                nt_mem[nt_slot(a)] = d;
                nt_set[nt_slot(a)] = 1'b1;
            end else begin
                pal_mem[pal_slot(a)] = d;
                pal_set[pal_slot(a)] = 1'b1;
            end
        endfunction

        function void step_addr();
            vaddr = vaddr + (ctrl[2] ? 16'd32 : 16'd1);
        endfunction

        function logic [7:0] cpu_read(logic [2:0] s);
            logic [7:0] r;
            r = '0;
            case (s)
                REG_STATUS: begin
                    r = {flags, 5'b00000};
                    flags[VblBit] = 1'b0;
                    toggle = 1'b0;
                end
                REG_OAMDATA: begin
                    r = spr_mem[oam_ptr];
                end
                REG_DATA: begin
                    r = rd_buffer;
                    rd_buffer = mem_read(vaddr[13:0]);
                    // palette reads bypass the buffer
                    if (vaddr[13:0] >= PAL_BASE) begin
                        r = rd_buffer;
                    end
                    step_addr();
                end
                default: ;
            endcase
            return r;
        endfunction

        function void cpu_write(logic [2:0] s, logic [7:0] d);
            case (s)
                REG_CTRL: begin
                    ctrl = d;
                    taddr[11:10] = d[1:0];
                end
                REG_MASK: msk = d;
                REG_OAMADDR: oam_ptr = d;
                REG_OAMDATA: begin
                    spr_mem[oam_ptr] = d;
                    spr_set[oam_ptr] = 1'b1;
                    oam_ptr = oam_ptr + 8'd1;
                end
                REG_SCROLL: begin
                    if (!toggle) begin
                        fine = d[2:0];
                        taddr[4:0] = d[7:3];
                    end else begin
                        taddr[14:12] = d[2:0];
                        taddr[9:5] = d[7:3];
                    end
                    toggle = !toggle;
                end
                REG_ADDR: begin
                    if (!toggle) begin
                        taddr = {2'b00, d[5:0], taddr[7:0]};
                    end else begin
                        taddr[7:0] = d;
                        vaddr = taddr;
                    end
                    toggle = !toggle;
                end
                REG_DATA: begin
                    mem_write(vaddr[13:0], d);
                    step_addr();
                end
                default: ;
            endcase
        endfunction

        // Apply one accepted access or event and queue the snapshot it owes.
        function void take_access(logic [2:0] f, logic [2:0] s, logic [7:0] d);
            reg_snapshot_t r;
            r = '0;
            case (f)
                FUNC_CPU_READ: r.read_data = cpu_read(s);
                FUNC_CPU_WRITE: cpu_write(s, d);
                FUNC_VBLANK: begin
                    flags[VblBit] = 1'b1;
                    r.nmi = ctrl[7];
                end
                FUNC_PRERENDER: flags = '0;
                FUNC_SPR0_HIT: flags[HitBit] = 1'b1;
                FUNC_OVERFLOW: flags[OvfBit] = 1'b1;
                default: ;
            endcase
            r.vram_addr = vaddr;
            r.temp_addr = taddr;
            r.fine_x    = fine;
            r.control   = ctrl;
            r.mask      = msk;
            owed_snapshots.push_back(r);
        endfunction

        function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_snapshot(logic [63:0] td);
            reg_snapshot_t e;
            if (owed_snapshots.size() == 0) begin
                $error("result %0h arrived with nothing outstanding", td);
                errors++;
                return;
            end
            e = owed_snapshots.pop_front();
            cmp_field("read_data", 16'(e.read_data), 16'(td[7:0]));
            cmp_field("nmi",       16'(e.nmi),       16'(td[8]));
            cmp_field("vram_addr", e.vram_addr,      td[24:9]);
            cmp_field("temp_addr", e.temp_addr,      td[40:25]);
            cmp_field("fine_x",    16'(e.fine_x),    16'(td[43:41]));
            cmp_field("control",   16'(e.control),   16'(td[51:44]));
            cmp_field("mask",      16'(e.mask),      16'(td[59:52]));
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [5:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;

    ppu_port_scoreboard sb;

    bit tx_calm  = 1'b0;   // sender offers back to back while set
    bit rx_calm  = 1'b0;   // receiver accepts back to back while set
    int hold_req = 0;      // pending long hold-off for the receiver
    int issued   = 0;
    int quiet    = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    ppu_register_and_vram_port DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Watchdog: count cycles with no transaction on any channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet + 1 >= StallLimit) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Result side: draw a stall per transaction, take the long hold-off when
    // asked, then check each accepted result against the oldest snapshot.
    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 6);
            if (hold_req > 0) begin
                gap = hold_req;
                hold_req = 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_snapshot(m_tdata);
            if ($urandom_range(0, 39) == 0) begin
                rx_calm = !rx_calm;
            end
        end
    end

    // Offer one item after a random gap and hold it until accepted; keep
    // tvalid high across back-to-back items.
    task automatic send_item(input logic [2:0] f, input logic [2:0] s, input logic [7:0] d);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {s, f};
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.take_access(f, s, d);
        if ($urandom_range(0, 39) == 0) begin
            tx_calm = !tx_calm;
        end
    endtask

    // Turn a read of a never-written memory entry into a write of that entry.
    function automatic logic [2:0] guard_read(input logic [2:0] f, input logic [2:0] s);
        if (f == FUNC_CPU_READ && s == REG_OAMDATA && !sb.spr_set[sb.oam_ptr]) begin
            return FUNC_CPU_WRITE;
        end
        if (f == FUNC_CPU_READ && s == REG_DATA && !sb.entry_written(sb.vaddr[13:0])) begin
            return FUNC_CPU_WRITE;
        end
        return f;
    endfunction

    task automatic issue(input logic [2:0] f, input logic [2:0] s, input logic [7:0] d);
        send_item(guard_read(f, s), s, d);
        issued++;
    endtask

    // Stop offering and wait until every owed result has been taken, then
    // let the pipeline settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write the mirroring register; only called with the block idle.
    task automatic write_mirror(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.mirror = v;
    endtask

    task automatic run_directed();
        // readable and unreadable registers straight out of reset
        send_item(FUNC_CPU_READ,  REG_STATUS,  8'h00);
        send_item(FUNC_CPU_READ,  REG_CTRL,    8'h00);
        send_item(FUNC_CPU_READ,  REG_SCROLL,  8'h00);
        // all control bits set: nmi enable, stride 32, nametable select
        send_item(FUNC_CPU_WRITE, REG_CTRL,    8'hFF);
        send_item(FUNC_CPU_WRITE, REG_MASK,    8'hFF);
        send_item(FUNC_CPU_WRITE, REG_STATUS,  8'hA5);
        // every flag event, then a status read that clears vblank
        send_item(FUNC_VBLANK,    REG_CTRL,    8'h00);
        send_item(FUNC_SPR0_HIT,  REG_CTRL,    8'h00);
        send_item(FUNC_OVERFLOW,  REG_CTRL,    8'h00);
        send_item(FUNC_CPU_READ,  REG_STATUS,  8'h00);
        send_item(FUNC_PRERENDER, REG_MASK,    8'h00);
        send_item(FUNC_SPARE6,    REG_DATA,    8'hFF);
        send_item(FUNC_SPARE7,    REG_ADDR,    8'h00);
        // sprite address wraps after the top entry
        send_item(FUNC_CPU_WRITE, REG_OAMADDR, 8'hFF);
        send_item(FUNC_CPU_WRITE, REG_OAMDATA, 8'h5A);
        send_item(FUNC_CPU_WRITE, REG_OAMADDR, 8'hFF);
        send_item(FUNC_CPU_READ,  REG_OAMDATA, 8'h00);
        send_item(FUNC_CPU_WRITE, REG_SCROLL,  8'hFF);
        send_item(FUNC_CPU_WRITE, REG_SCROLL,  8'h00);
        // top of the video space, then a stride-32 step past it
        send_item(FUNC_CPU_WRITE, REG_ADDR,    8'hFF);
        send_item(FUNC_CPU_WRITE, REG_ADDR,    8'hFF);
        send_item(FUNC_CPU_WRITE, REG_DATA,    8'h00);
        send_item(FUNC_CPU_WRITE, REG_CTRL,    8'h00);
        // sprite backdrop aliases to the background one; palette read is direct
        send_item(FUNC_CPU_WRITE, REG_ADDR,    8'h3F);
        send_item(FUNC_CPU_WRITE, REG_ADDR,    8'h10);
        send_item(FUNC_CPU_WRITE, REG_DATA,    8'h77);
        send_item(FUNC_CPU_WRITE, REG_ADDR,    8'h3F);
        send_item(FUNC_CPU_WRITE, REG_ADDR,    8'h00);
        send_item(FUNC_CPU_READ,  REG_DATA,    8'h00);
    endtask

    // Address pair, then a run on the data port; sometimes write a run and
    // read it back from the same start.
    task automatic addr_sequence();
        logic [7:0] hi;
        logic [7:0] lo;
        int len;
        case ($urandom_range(0, 2))
            0: hi = 8'($urandom_range(0, 31));
            1: hi = 8'($urandom_range(32, 62));
            default: hi = 8'h3F;
        endcase
        hi[7:6] = 2'($urandom_range(0, 3));
        lo = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) :
                                           8'($urandom_range(0, 255));
        len = $urandom_range(1, 8);
        if ($urandom_range(0, 2) == 0) begin
            issue(FUNC_CPU_READ, REG_STATUS, 8'($urandom_range(0, 255)));
        end
        issue(FUNC_CPU_WRITE, REG_ADDR, hi);
        issue(FUNC_CPU_WRITE, REG_ADDR, lo);
        if ($urandom_range(0, 1) == 0) begin
            repeat (len) begin
                issue($urandom_range(0, 1) ? FUNC_CPU_WRITE : FUNC_CPU_READ, REG_DATA,
                      8'($urandom_range(0, 255)));
            end
        end else begin
            repeat (len) issue(FUNC_CPU_WRITE, REG_DATA, 8'($urandom_range(0, 255)));
            issue(FUNC_CPU_WRITE, REG_ADDR, hi);
            issue(FUNC_CPU_WRITE, REG_ADDR, lo);
            repeat (len) issue(FUNC_CPU_READ, REG_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int count);
        int target;
        int len;
        target = issued + count;
        while (issued < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: addr_sequence();
                4: begin
                    issue(FUNC_CPU_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
                    issue(FUNC_CPU_WRITE, REG_SCROLL, 8'($urandom_range(0, 255)));
                end
                5: begin
                    len = $urandom_range(1, 6);
                    issue(FUNC_CPU_WRITE, REG_OAMADDR, 8'($urandom_range(0, 255)));
                    repeat (len) begin
                        issue($urandom_range(0, 1) ? FUNC_CPU_WRITE : FUNC_CPU_READ,
                              REG_OAMDATA, 8'($urandom_range(0, 255)));
                    end
                end
                6: issue(FUNC_CPU_WRITE, $urandom_range(0, 1) ? REG_CTRL : REG_MASK,
                         8'($urandom_range(0, 255)));
                7: begin
                    issue(3'($urandom_range(FUNC_VBLANK, FUNC_OVERFLOW)),
                          3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1) == 0) begin
                        issue(FUNC_CPU_READ, REG_STATUS, 8'($urandom_range(0, 255)));
                    end
                end
                8: issue(FUNC_CPU_READ, REG_STATUS, 8'($urandom_range(0, 255)));
                default: issue(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                               8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // Walk the data port at stride 32 from near the top of the video space,
    // past the point where the address leaves the 14-bit bus and folds back
    // onto pattern space, with a sprinkling of harmless traffic.
    task automatic run_stride_sweep(input int count);
        logic [7:0] cfg_byte;
        int         target;
        cfg_byte = 8'($urandom_range(0, 255));
        cfg_byte[2] = 1'b1;
        issue(FUNC_CPU_WRITE, REG_CTRL, cfg_byte);
        issue(FUNC_CPU_READ, REG_STATUS, 8'h00);
        issue(FUNC_CPU_WRITE, REG_ADDR, 8'h3F);
        issue(FUNC_CPU_WRITE, REG_ADDR, 8'hE0);
        target = issued + count;
        while (issued < target) begin
            if ($urandom_range(0, 9) != 0) begin
                issue($urandom_range(0, 1) ? FUNC_CPU_WRITE : FUNC_CPU_READ, REG_DATA,
                      8'($urandom_range(0, 255)));
            end else begin
                case ($urandom_range(0, 2))
                    0: issue(FUNC_CPU_WRITE, REG_OAMDATA, 8'($urandom_range(0, 255)));
                    1: issue(3'($urandom_range(FUNC_VBLANK, FUNC_OVERFLOW)),
                             3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                    default: issue(FUNC_CPU_WRITE, REG_MASK, 8'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // horizontal mirroring: directed checks, then random traffic under a
        // long result-side hold-off that backs up the input
        write_mirror(1'b0);
        run_directed();
        hold_req = HoldCycles;
        run_random(300);
        drain_results();
        // vertical mirroring
        write_mirror(1'b1);
        run_random(300);
        drain_results();
        run_stride_sweep(120);
        drain_results();
        // back to horizontal over memory written under the other fold
        write_mirror(1'b0);
        run_random(400);
        drain_results();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/ppu_rvp_pkg.sv
rtl/ppu_rvp_ram.sv
rtl/ppu_rvp_core.sv
rtl/ppu_register_and_vram_port.sv
rtl/ppu_rvp_checker.sv
sim/ppu_register_and_vram_port_tb.sv
